>>> hdl/cst_pkg.sv
`default_nettype none
package cst_pkg;

    // fixed shape of the operation set and the result fields
    localparam int NUM_OPS  = 11;
    localparam int OP_BITS  = 4;
    localparam int OUT_BITS = 32;

    typedef logic [OP_BITS-1:0] op_kind_t;

    // operation indexes, in result order
    localparam op_kind_t OP_M   = 4'd0;
    localparam op_kind_t OP_I   = 4'd1;
    localparam op_kind_t OP_D   = 4'd2;
    localparam op_kind_t OP_N   = 4'd3;
    localparam op_kind_t OP_S   = 4'd4;
    localparam op_kind_t OP_H   = 4'd5;
    localparam op_kind_t OP_P   = 4'd6;
    localparam op_kind_t OP_EQ  = 4'd7;
    localparam op_kind_t OP_X   = 4'd8;
    localparam op_kind_t OP_B   = 4'd9;
    localparam op_kind_t OP_V   = 4'd10;
    localparam op_kind_t LAST_OP = OP_V;

    // ascii codes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_X       = 8'h58;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_V       = 8'h56;

    // ops that consume read bases: M I S = X V
    localparam logic [NUM_OPS-1:0] QUERY_MASK = 11'b101_1001_0011;
    // ops that consume reference bases: M D N = X V
    localparam logic [NUM_OPS-1:0] REF_MASK   = 11'b101_1000_1101;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        op_kind_t              op_kind;
        logic [OUT_BITS-1:0]   op_total;
        logic [OUT_BITS-1:0]   query_length;
        logic [OUT_BITS-1:0]   reference_length;
        logic                  malformed;
        logic                  last_of_run;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic     take_char;
        logic     load_out;
        logic     clear;
        op_kind_t out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic     hit;
        op_kind_t kind;
    } op_match_t;

    // case-insensitive op letter lookup
    function automatic op_match_t find_op(input logic [7:0] ch);
        logic [7:0] upper;
        op_match_t  res;
        upper = (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) ? ch - CASE_SHIFT : ch;
        res.hit  = 1'b1;
        res.kind = OP_M;
        case (upper)
            CH_M:    res.kind = OP_M;
            CH_I:    res.kind = OP_I;
            CH_D:    res.kind = OP_D;
            CH_N:    res.kind = OP_N;
            CH_S:    res.kind = OP_S;
            CH_H:    res.kind = OP_H;
            CH_P:    res.kind = OP_P;
            CH_EQ:   res.kind = OP_EQ;
            CH_X:    res.kind = OP_X;
            CH_B:    res.kind = OP_B;
            CH_V:    res.kind = OP_V;
            default: res.hit  = 1'b0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hdl/cst_ctrl.sv
`default_nettype none
module cst_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              eos,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cst_pkg::dp_cmd_t       cmd
);
    import cst_pkg::*;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic     state_reg, state_next;
    op_kind_t idx_reg, idx_next;
    logic     m_valid_reg, m_valid_next;
    logic     out_free;
    logic     accept;

    assign s_ready  = (state_reg == ST_RUN);
    assign m_valid  = m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.out_idx  = idx_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_RUN: begin
                cmd.take_char = accept;
                if (accept && eos) begin
                    state_next = ST_EMIT;
                    idx_next   = OP_M;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    if (idx_reg == LAST_OP) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_RUN;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            idx_reg     <= OP_M;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // final char starts the summary run at the first op
    a_final_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && eos |=> state_reg == ST_EMIT && idx_reg == OP_M)
        else $error("summary run did not start at first op");

    // loading the last op ends the run
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out && idx_reg == LAST_OP |=> state_reg == ST_RUN && m_valid_reg)
        else $error("summary run did not end after last op");

    // op index stays in range
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_OP)
        else $error("op index out of range");

endmodule
`default_nettype wire

>>> hdl/cst_dp.sv
`default_nettype none
module cst_dp #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cst_pkg::in_item_t s_item,
    input  wire cst_pkg::dp_cmd_t  cmd,
    output cst_pkg::out_item_t     m_item
);
    import cst_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] run_reg, run_next;
    logic                  pend_reg, pend_next;
    logic [COUNT_BITS-1:0] tot_reg [NUM_OPS];
    logic [COUNT_BITS-1:0] tot_next [NUM_OPS];
    logic [COUNT_BITS-1:0] q_reg, q_next;
    logic [COUNT_BITS-1:0] r_reg, r_next;
    logic                  err_reg, err_next;
    out_item_t             out_reg;

    logic                  is_digit;
    logic [3:0]            digit_val;
    logic [COUNT_BITS+3:0] run_ext;
    logic [COUNT_BITS+3:0] run_x10;
    op_match_t             op;
    logic                  add_op;
    logic [COUNT_BITS-1:0] op_sum;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

    // character decode
    assign is_digit  = s_item.char_code inside {[CH_ZERO:CH_NINE]};
    assign digit_val = 4'(s_item.char_code - CH_ZERO);
    assign op        = find_op(s_item.char_code);
    assign add_op    = cmd.take_char && !is_digit && op.hit;

    // run length times ten plus digit, by shift and add
    assign run_ext = {4'b0, run_reg};
    assign run_x10 = (run_ext << 3) + (run_ext << 1) + (COUNT_BITS + 4)'(digit_val);

    // total of the matched op, plus the pending run
    assign op_sum = sat_add(tot_reg[op.kind], run_reg);

    // state update
    always_comb begin
        run_next  = run_reg;
        pend_next = pend_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        err_next  = err_reg;
        for (int k = 0; k < NUM_OPS; k++) begin
            tot_next[k] = tot_reg[k];
        end
        if (cmd.clear) begin
            run_next  = '0;
            pend_next = 1'b0;
            q_next    = '0;
            r_next    = '0;
            err_next  = 1'b0;
            for (int k = 0; k < NUM_OPS; k++) begin
                tot_next[k] = '0;
            end
        end else if (cmd.take_char) begin
            if (is_digit) begin
                run_next  = (run_x10[COUNT_BITS+3:COUNT_BITS] != 4'd0) ?
                            CNT_MAX : run_x10[COUNT_BITS-1:0];
                pend_next = 1'b1;
                // digits left over at the end of the string
                if (s_item.end_of_string) begin
                    err_next = 1'b1;
                end
            end else begin
                run_next  = '0;
                pend_next = 1'b0;
                if (!op.hit) begin
                    err_next = 1'b1;
                end
            end
            if (add_op) begin
                for (int k = 0; k < NUM_OPS; k++) begin
                    if (op.kind == OP_BITS'(k)) begin
                        tot_next[k] = op_sum;
                    end
                end
                if (QUERY_MASK[op.kind]) begin
                    q_next = sat_add(q_reg, run_reg);
                end
                if (REF_MASK[op.kind]) begin
                    r_next = sat_add(r_reg, run_reg);
                end
            end
        end
    end

    // tally registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= '0;
            pend_reg <= 1'b0;
            q_reg    <= '0;
            r_reg    <= '0;
            err_reg  <= 1'b0;
            for (int k = 0; k < NUM_OPS; k++) begin
                tot_reg[k] <= '0;
            end
        end else begin
            run_reg  <= run_next;
            pend_reg <= pend_next;
            q_reg    <= q_next;
            r_reg    <= r_next;
            err_reg  <= err_next;
            for (int k = 0; k < NUM_OPS; k++) begin
                tot_reg[k] <= tot_next[k];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.op_kind          <= cmd.out_idx;
            out_reg.op_total         <= OUT_BITS'(tot_reg[cmd.out_idx]);
            out_reg.query_length     <= OUT_BITS'(q_reg);
            out_reg.reference_length <= OUT_BITS'(r_reg);
            out_reg.malformed        <= err_reg;
            out_reg.last_of_run      <= (cmd.out_idx == LAST_OP);
        end
    end

    assign m_item = out_reg;

    // end of a summary run leaves the tally empty
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> q_reg == '0 && r_reg == '0 && !err_reg && !pend_reg && run_reg == '0)
        else $error("tally not cleared after summary run");

    // an op letter or illegal char drops the pending run
    a_non_digit_drops_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_char && !is_digit |=> run_reg == '0 && !pend_reg)
        else $error("pending run survived a non-digit");

    // no char is taken while results are being loaded
    a_load_excludes_take: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_out && cmd.take_char))
        else $error("char taken during summary run");

endmodule
`default_nettype wire

>>> hdl/cigar_string_tally.sv
`default_nettype none
// non-final chars: one item per cycle, tally updated at the accepting edge
// final char: the controller enters its emit state, then the eleven results are
// registered at one per cycle while m_ready stays high, set by the emit counter
// input is taken again the cycle after the eleventh result is loaded
// reset (aresetn low, synchronous) clears all totals, flags, the run and m_valid
module cigar_string_tally #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cst_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cst_pkg::out_item_t      m_item
);
    import cst_pkg::*;

    dp_cmd_t cmd;

    // sequencer
    cst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .eos     (s_item.end_of_string),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // tally and result register
    cst_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire

>>> dv/cigar_string_tally_tb.sv
`timescale 1ns / 1ps
module cigar_string_tally_tb;
    import cst_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_CHARS = 150;
    localparam int          IDLE_PCT     = 20;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam longint      CYCLE_LIMIT  = 200000;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    // op letters in result order
    localparam logic [7:0] OP_LETTERS [NUM_OPS] = '{
        "M", "I", "D", "N", "S", "H", "P", "=", "X", "B", "V"
    };
    // ops that consume read bases and reference bases
    localparam logic [NUM_OPS-1:0] READ_OPS = (11'd1 << OP_M) | (11'd1 << OP_I)
        | (11'd1 << OP_S) | (11'd1 << OP_EQ) | (11'd1 << OP_X) | (11'd1 << OP_V);
    localparam logic [NUM_OPS-1:0] REF_OPS = (11'd1 << OP_M) | (11'd1 << OP_D)
        | (11'd1 << OP_N) | (11'd1 << OP_EQ) | (11'd1 << OP_X) | (11'd1 << OP_V);

    // running cigar tally and the summaries it expects from the block
    class tally_scoreboard;
        logic [31:0] run_len;
        bit          digits_seen;
        logic [31:0] op_sum [NUM_OPS];
        logic [31:0] read_len;
        logic [31:0] ref_len;
        bit          bad_string;
        out_item_t   summary_q [$];
        int          fail_count;

        function new();
            fail_count = 0;
            clear_tally();
        endfunction

        function void clear_tally();
            run_len     = '0;
            digits_seen = 1'b0;
            foreach (op_sum[k]) op_sum[k] = '0;
            read_len    = '0;
            ref_len     = '0;
            bad_string  = 1'b0;
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[32] ? COUNT_MAX : sum[31:0];
        endfunction

        // case-insensitive op lookup, -1 when the char is no op letter
        function int op_index(logic [7:0] ch);
            logic [7:0] upper;
            upper = (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ? ch - CASE_SHIFT : ch;
            for (int k = 0; k < NUM_OPS; k++) begin
                if (OP_LETTERS[k] == upper) return k;
            end
            return -1;
        endfunction

        function void note_char(in_item_t it);
            logic [63:0] digit;
            int          kind;
            out_item_t   want;
            // digits extend the run, saturating
            if (it.char_code >= CH_ZERO && it.char_code <= CH_NINE) begin
                digit = 64'(it.char_code - CH_ZERO);
                if (64'(run_len) > (64'(COUNT_MAX) - digit) / 10) begin
                    run_len = COUNT_MAX;
                end else begin
                    run_len = 32'(64'(run_len) * 10 + digit);
                end
                digits_seen = 1'b1;
            end else begin
                kind = op_index(it.char_code);
                if (kind >= 0) begin
                    op_sum[kind] = sat_add(op_sum[kind], run_len);
                    if (READ_OPS[kind]) read_len = sat_add(read_len, run_len);
                    if (REF_OPS[kind]) ref_len = sat_add(ref_len, run_len);
                end else begin
                    bad_string = 1'b1;
                end
                run_len     = '0;
                digits_seen = 1'b0;
            end
            if (!it.end_of_string) return;
            // trailing digits make the string malformed
            if (digits_seen) bad_string = 1'b1;
            for (int k = 0; k < NUM_OPS; k++) begin
                want.op_kind          = op_kind_t'(k);
                want.op_total         = op_sum[k];
                want.query_length     = read_len;
                want.reference_length = ref_len;
                want.malformed        = bad_string;
                want.last_of_run      = (op_kind_t'(k) == LAST_OP);
                summary_q.push_back(want);
            end
            clear_tally();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (summary_q.size() == 0) begin
                $error("result with nothing pending: op_kind %0d op_total %0d",
                       got.op_kind, got.op_total);
                fail_count++;
                return;
            end
            want = summary_q.pop_front();
            compare_field("op_kind", 32'(want.op_kind), 32'(got.op_kind));
            compare_field("op_total", want.op_total, got.op_total);
            compare_field("query_length", want.query_length, got.query_length);
            compare_field("reference_length", want.reference_length, got.reference_length);
            compare_field("malformed", 32'(want.malformed), 32'(got.malformed));
            compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        endfunction

        function int pending();
            return summary_q.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    tally_scoreboard sb;
    bit     tx_idle_on  = 1'b1;
    bit     rx_idle_on  = 1'b1;
    int     hold_asked  = 0;
    int     chars_sent  = 0;
    longint cycle_count = 0;

    cigar_string_tally u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cigar_string_tally test failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin : receiver
        int hold_left;
        int holds_done;
        m_ready    = 1'b0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && holds_done != hold_asked) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_idle_on || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // offer one item, with random idle cycles ahead of it
    task automatic send_char(input in_item_t it);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_char(it);
        chars_sent++;
    endtask

    // one whole string, end flag on its last char
    task automatic send_seq(input logic [7:0] chars [$]);
        in_item_t it;
        foreach (chars[k]) begin
            it.char_code     = chars[k];
            it.end_of_string = (k == chars.size() - 1);
            send_char(it);
        end
    endtask

    task automatic send_text(input string text);
        logic [7:0] chars [$];
        for (int k = 0; k < text.len(); k++) chars.push_back(text[k]);
        send_seq(chars);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // random cigar: mostly well formed, heavy ones saturate, noisy ones usually break it
    task automatic send_random_cigar(input bit noisy, input bit heavy);
        logic [7:0] chars [$];
        logic [7:0] letter;
        int         n_ops;
        int         n_digits;
        int         pick;
        int         dice;
        n_ops = heavy ? 3 : $urandom_range(1, 6);
        pick  = $urandom_range(0, NUM_OPS - 1);
        for (int j = 0; j < n_ops; j++) begin
            dice = $urandom_range(0, 99);
            if (heavy) n_digits = 10;
            else if (dice < 8) n_digits = 0;
            else if (dice < 88) n_digits = $urandom_range(1, 3);
            else if (dice < 97) n_digits = $urandom_range(4, 7);
            else n_digits = $urandom_range(10, 12);
            for (int d = 0; d < n_digits; d++) begin
                chars.push_back(CH_ZERO + 8'((heavy && d == 0) ? 9 : $urandom_range(0, 9)));
            end
            if (!heavy) pick = $urandom_range(0, NUM_OPS - 1);
            letter = OP_LETTERS[pick];
            if (letter != OP_LETTERS[OP_EQ] && $urandom_range(0, 1)) letter = letter + CASE_SHIFT;
            chars.push_back(letter);
        end
        if (noisy) begin
            dice = $urandom_range(0, 2);
            if (dice == 0) begin
                chars.insert($urandom_range(0, chars.size()), 8'($urandom_range(0, 255)));
            end else if (dice == 1) begin
                repeat ($urandom_range(1, 3)) chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end else begin
                chars.delete();
                repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_seq(chars);
    endtask

    // stimulus
    initial begin : stimulus
        logic [7:0] odd_chars [$];
        int         n_strings;
        int         dice;
        s_valid = 1'b0;
        s_item  = '0;
        aresetn = 1'b0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every op in mixed case, bare op letter, illegal bytes, trailing digits
        send_text("1M2i3D4n5S6h7P8=9x0B1v");
        send_text("M");
        odd_chars = {8'hFF, CH_ZERO + 8'd5};
        send_seq(odd_chars);
        odd_chars = {8'h00};
        send_seq(odd_chars);
        send_text(" +-2M");

        // random strings
        chars_sent = 0;
        n_strings  = 0;
        while (chars_sent < RANDOM_CHARS) begin
            // long receiver hold-off while strings keep coming
            if (n_strings == 3) hold_asked++;
            // sender pause until the block has emptied
            if (n_strings == 6) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            tx_idle_on = !(chars_sent >= 70 && chars_sent < 120);
            rx_idle_on = tx_idle_on;
            dice = $urandom_range(0, 99);
            send_random_cigar(dice < 15, dice >= 90);
            n_strings++;
        end
        s_valid <= 1'b0;
        wait_drained();

        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("cigar_string_tally test passed");
        end else begin
            $display("cigar_string_tally test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/cst_pkg.sv
hdl/cst_ctrl.sv
hdl/cst_dp.sv
hdl/cigar_string_tally.sv
dv/cigar_string_tally_tb.sv
